FILE: src/nnd_pkg.sv
// Shared types and constants for the nearest-neighbor downscaler.
package nnd_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_SIDE_W  = 14;
    localparam int CFG_MAX_W   = 11;
    localparam int CFG_DATA_W  = 14;

    localparam logic [CFG_SIDE_W-1:0] SOURCE_WIDTH_RESET  = 14'd640;
    localparam logic [CFG_SIDE_W-1:0] SOURCE_HEIGHT_RESET = 14'd480;
    localparam logic [CFG_MAX_W-1:0]  MAX_DIMENSION_RESET = 11'd512;

    localparam logic [CFG_MAX_W-1:0]  MAX_DIMENSION_LOW  = 11'd256;
    localparam logic [CFG_MAX_W-1:0]  MAX_DIMENSION_HIGH = 11'd1024;

    localparam int QUOT_W  = CFG_MAX_W;
    localparam int PIXEL_W = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_MAX_DIMENSION = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        CALC_IDLE,
        CALC_LOAD,
        CALC_DIV,
        CALC_FINISH
    } calc_state_t;

    typedef struct packed {
        logic       row_end;
        logic       frame_end;
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

endpackage

FILE: src/nnd_size_calc.sv
// Configuration registers and sequential output-size calculation.
module nnd_size_calc
    import nnd_pkg::*;
#(
    parameter int MAX_SIDE = 8192,
    parameter int SW = 14
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   restart,
    output logic                   busy,
    output logic [SW-1:0]          eff_w,
    output logic [SW-1:0]          eff_h,
    output logic [SW-1:0]          out_w,
    output logic [SW-1:0]          out_h
);

    localparam int EW = (SW > CFG_SIDE_W) ? SW : CFG_SIDE_W;
    localparam int LW = (SW > CFG_MAX_W) ? SW : CFG_MAX_W;
    localparam int NW = SW + CFG_MAX_W + 1;
    localparam int CW = $clog2(QUOT_W);

    logic [CFG_SIDE_W-1:0] src_w_reg;
    logic [CFG_SIDE_W-1:0] src_h_reg;
    logic [CFG_MAX_W-1:0]  max_dim_reg;

    calc_state_t state_reg;
    calc_state_t state_next;

    logic [SW-1:0]     eff_w_reg;
    logic [SW-1:0]     eff_h_reg;
    logic              scale_reg;
    logic [NW-1:0]     rem_w_reg;
    logic [NW-1:0]     rem_h_reg;
    logic [NW-1:0]     dsh_reg;
    logic [QUOT_W-1:0] q_w_reg;
    logic [QUOT_W-1:0] q_h_reg;
    logic [CW-1:0]     cnt_reg;
    logic [SW-1:0]     out_w_reg;
    logic [SW-1:0]     out_h_reg;

    logic [EW-1:0]        wide_w;
    logic [EW-1:0]        wide_h;
    logic [SW-1:0]        eff_w_c;
    logic [SW-1:0]        eff_h_c;
    logic [CFG_MAX_W-1:0] m_c;
    logic [SW-1:0]        longest_c;
    logic                 take_w;
    logic                 take_h;
    logic [QUOT_W-1:0]    q_w_fix;
    logic [QUOT_W-1:0]    q_h_fix;

    always_comb
    begin
        restart = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SOURCE_WIDTH:  restart = 1'b1;
                CFG_SOURCE_HEIGHT: restart = 1'b1;
                CFG_MAX_DIMENSION: restart = 1'b1;
                default:           restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg   <= SOURCE_WIDTH_RESET;
            src_h_reg   <= SOURCE_HEIGHT_RESET;
            max_dim_reg <= MAX_DIMENSION_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SOURCE_WIDTH:  src_w_reg   <= cfg_data[CFG_SIDE_W-1:0];
                CFG_SOURCE_HEIGHT: src_h_reg   <= cfg_data[CFG_SIDE_W-1:0];
                CFG_MAX_DIMENSION: max_dim_reg <= cfg_data[CFG_MAX_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        wide_w = EW'(src_w_reg);
        wide_h = EW'(src_h_reg);
        if (wide_w == '0)
            eff_w_c = SW'(1);
        else if (wide_w > EW'(MAX_SIDE))
            eff_w_c = SW'(MAX_SIDE);
        else
            eff_w_c = SW'(wide_w);
        if (wide_h == '0)
            eff_h_c = SW'(1);
        else if (wide_h > EW'(MAX_SIDE))
            eff_h_c = SW'(MAX_SIDE);
        else
            eff_h_c = SW'(wide_h);
        if (max_dim_reg < MAX_DIMENSION_LOW)
            m_c = MAX_DIMENSION_LOW;
        else if (max_dim_reg > MAX_DIMENSION_HIGH)
            m_c = MAX_DIMENSION_HIGH;
        else
            m_c = max_dim_reg;
        longest_c = (eff_w_c > eff_h_c) ? eff_w_c : eff_h_c;
    end

    assign take_w  = rem_w_reg >= dsh_reg;
    assign take_h  = rem_h_reg >= dsh_reg;
    assign q_w_fix = (q_w_reg == '0) ? QUOT_W'(1) : q_w_reg;
    assign q_h_fix = (q_h_reg == '0) ? QUOT_W'(1) : q_h_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CALC_IDLE:   state_next = CALC_IDLE;
            CALC_LOAD:   state_next = CALC_DIV;
            CALC_DIV:    state_next = (cnt_reg == '0) ? CALC_FINISH : CALC_DIV;
            CALC_FINISH: state_next = CALC_IDLE;
            default:     state_next = CALC_IDLE;
        endcase
        if (restart)
            state_next = CALC_LOAD;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CALC_LOAD;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            CALC_LOAD:
            begin
                eff_w_reg <= eff_w_c;
                eff_h_reg <= eff_h_c;
                scale_reg <= LW'(longest_c) > LW'(m_c);
                rem_w_reg <= ((NW'(eff_w_c) * NW'(m_c)) << 1) + NW'(longest_c);
                rem_h_reg <= ((NW'(eff_h_c) * NW'(m_c)) << 1) + NW'(longest_c);
                dsh_reg   <= NW'(longest_c) << QUOT_W;
                cnt_reg   <= CW'(QUOT_W - 1);
            end
            CALC_DIV:
            begin
                if (take_w)
                    rem_w_reg <= rem_w_reg - dsh_reg;
                if (take_h)
                    rem_h_reg <= rem_h_reg - dsh_reg;
                q_w_reg <= {q_w_reg[QUOT_W-2:0], take_w};
                q_h_reg <= {q_h_reg[QUOT_W-2:0], take_h};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - CW'(1);
            end
            CALC_FINISH:
            begin
                out_w_reg <= scale_reg ? SW'(q_w_fix) : eff_w_reg;
                out_h_reg <= scale_reg ? SW'(q_h_fix) : eff_h_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign busy  = state_reg != CALC_IDLE;
    assign eff_w = eff_w_reg;
    assign eff_h = eff_h_reg;
    assign out_w = out_w_reg;
    assign out_h = out_h_reg;

endmodule

FILE: src/nnd_raster.sv
// Raster position counters and nearest-neighbor keep decision.
module nnd_raster
    import nnd_pkg::*;
#(
    parameter int SW = 14
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          advance,
    input  logic [SW-1:0] eff_w,
    input  logic [SW-1:0] eff_h,
    input  logic [SW-1:0] out_w,
    input  logic [SW-1:0] out_h,
    output logic          kept,
    output logic          row_end,
    output logic          frame_end
);

    localparam int PW = 2 * SW;

    logic [SW-1:0] src_col_reg;
    logic [SW-1:0] src_row_reg;
    logic [SW-1:0] out_col_reg;
    logic [SW-1:0] out_row_reg;
    logic [PW-1:0] col_num_reg;
    logic [PW-1:0] row_num_reg;
    logic [PW-1:0] col_pos_reg;
    logic [PW-1:0] row_pos_reg;

    logic row_kept;
    logic col_kept;
    logic last_col;
    logic last_row;

    assign row_kept  = (row_pos_reg <= row_num_reg)
                     && (row_num_reg < row_pos_reg + PW'(out_h));
    assign col_kept  = (col_pos_reg <= col_num_reg)
                     && (col_num_reg < col_pos_reg + PW'(out_w));
    assign kept      = row_kept && col_kept;
    assign row_end   = ({1'b0, out_col_reg} + (SW+1)'(1)) == {1'b0, out_w};
    assign frame_end = row_end
                     && (({1'b0, out_row_reg} + (SW+1)'(1)) == {1'b0, out_h});
    assign last_col  = ({1'b0, src_col_reg} + (SW+1)'(1)) >= {1'b0, eff_w};
    assign last_row  = ({1'b0, src_row_reg} + (SW+1)'(1)) >= {1'b0, eff_h};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            col_num_reg <= '0;
            row_num_reg <= '0;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (clear)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            col_num_reg <= '0;
            row_num_reg <= '0;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
        end
        else if (advance)
        begin
            if (last_col)
            begin
                src_col_reg <= '0;
                col_pos_reg <= '0;
                out_col_reg <= '0;
                col_num_reg <= '0;
                if (last_row)
                begin
                    src_row_reg <= '0;
                    row_pos_reg <= '0;
                    out_row_reg <= '0;
                    row_num_reg <= '0;
                end
                else
                begin
                    src_row_reg <= src_row_reg + SW'(1);
                    row_pos_reg <= row_pos_reg + PW'(out_h);
                    if (row_kept)
                    begin
                        out_row_reg <= out_row_reg + SW'(1);
                        row_num_reg <= row_num_reg + PW'(eff_h);
                    end
                end
            end
            else
            begin
                src_col_reg <= src_col_reg + SW'(1);
                col_pos_reg <= col_pos_reg + PW'(out_w);
                if (kept)
                begin
                    out_col_reg <= out_col_reg + SW'(1);
                    col_num_reg <= col_num_reg + PW'(eff_w);
                end
            end
        end
    end

endmodule

FILE: src/nnd_out_buf.sv
// Two-entry output buffer with skid register for the result stream.
module nnd_out_buf
    import nnd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  pixel_t in_item,
    output logic   out_valid,
    input  logic   out_ready,
    output pixel_t out_item
);

    logic   out_valid_reg;
    logic   skid_valid_reg;
    pixel_t out_item_reg;
    pixel_t skid_item_reg;

    assign in_ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_valid;
            end
        end
        else if (in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
                out_item_reg <= skid_item_reg;
            else if (in_valid)
                out_item_reg <= in_item;
        end
        else if (in_valid)
        begin
            skid_item_reg <= in_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: src/nearest_neighbor_downscaler.sv
// Top level of the nearest-neighbor frame downscaler.
//
// Accepts one RGBA source pixel per clock in raster order while s_tready is
// high and emits the kept pixels in BGRA order, with tuser marking the last
// pixel of an output row and tlast the last pixel of the output frame. The
// keep decision depends only on the raster counters, so a dropped pixel is
// taken even while the output is stalled; kept pixels pass through a two-entry
// output buffer. After reset and after every register write the output size
// is recomputed by a bit-per-cycle divider: s_tready stays low while it runs,
// and the counters restart at the top of a frame.
module nearest_neighbor_downscaler
    import nnd_pkg::*;
#(
    parameter int MAX_SIDE = 8192
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [PIXEL_W-1:0]     s_tdata,   // red, green, blue, alpha
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [PIXEL_W-1:0]     m_tdata,   // out_blue, out_green, out_red, out_alpha
    output logic                   m_tlast,
    output logic                   m_tuser,   // row_end
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SW = $clog2(MAX_SIDE + 1);

    logic          restart;
    logic          busy;
    logic [SW-1:0] eff_w;
    logic [SW-1:0] eff_h;
    logic [SW-1:0] out_w;
    logic [SW-1:0] out_h;
    logic          kept;
    logic          row_end;
    logic          frame_end;
    logic          accept;
    logic          buf_ready;
    pixel_t        in_item;
    pixel_t        out_item;

    assign cfg_ready = 1'b1;

    nnd_size_calc #(
        .MAX_SIDE (MAX_SIDE),
        .SW       (SW)
    ) u_size_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .restart   (restart),
        .busy      (busy),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .out_w     (out_w),
        .out_h     (out_h)
    );

    assign s_tready = !busy && (!kept || buf_ready);
    assign accept   = s_tvalid && s_tready;

    nnd_raster #(
        .SW (SW)
    ) u_raster (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (restart),
        .advance   (accept),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .out_w     (out_w),
        .out_h     (out_h),
        .kept      (kept),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    always_comb
    begin
        in_item.row_end   = row_end;
        in_item.frame_end = frame_end;
        in_item.red       = s_tdata[7:0];
        in_item.green     = s_tdata[15:8];
        in_item.blue      = s_tdata[23:16];
        in_item.alpha     = s_tdata[31:24];
    end

    nnd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept && kept),
        .in_ready  (buf_ready),
        .in_item   (in_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {out_item.alpha, out_item.red, out_item.green, out_item.blue};
    assign m_tlast = out_item.frame_end;
    assign m_tuser = out_item.row_end;

endmodule

FILE: dv/nearest_neighbor_downscaler_test.sv
// Self-checking testbench for the nearest-neighbor frame downscaler.
module nearest_neighbor_downscaler_test
    import nnd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE_LIMIT     = 8192;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [PIXEL_W-1:0]     s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [PIXEL_W-1:0]     m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // register copies and frame geometry
    logic [CFG_SIDE_W-1:0] reg_width;
    logic [CFG_SIDE_W-1:0] reg_height;
    logic [CFG_MAX_W-1:0]  reg_max;
    logic [13:0]           eff_w;
    logic [13:0]           eff_h;
    logic [12:0]           out_width;
    logic [12:0]           out_height;

    // raster position
    logic [12:0] src_col;
    logic [12:0] src_row;
    logic [12:0] out_col;
    logic [12:0] out_row;
    logic [25:0] col_numer;
    logic [25:0] row_numer;

    pixel_t kept_pixels[$];

    int  failures    = 0;
    int  items_sent  = 0;
    int  quiet_count = 0;
    int  sink_hold   = 0;
    bit  no_idle     = 1'b0;

    nearest_neighbor_downscaler #(
        .MAX_SIDE(SIDE_LIMIT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // red, green, blue, alpha
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // out_blue, out_green, out_red, out_alpha
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),    // row_end
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 2) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [12:0] scale_side(input logic [13:0] side,
                                               input logic [10:0] limit,
                                               input logic [13:0] longest);
        longint unsigned q;
        q = (64'(side) * 64'(limit) * 2 + 64'(longest)) / (64'(longest) * 2);
        if (q == 0)
        begin
            q = 1;
        end
        return q[12:0];
    endfunction

    task automatic restart_geometry();
        logic [10:0] limit;
        logic [13:0] longest;
        eff_w = (reg_width == 0) ? 14'd1 :
                (reg_width > SIDE_LIMIT) ? 14'(SIDE_LIMIT) : reg_width;
        eff_h = (reg_height == 0) ? 14'd1 :
                (reg_height > SIDE_LIMIT) ? 14'(SIDE_LIMIT) : reg_height;
        limit = (reg_max < MAX_DIMENSION_LOW)  ? MAX_DIMENSION_LOW :
                (reg_max > MAX_DIMENSION_HIGH) ? MAX_DIMENSION_HIGH : reg_max;
        longest = (eff_w > eff_h) ? eff_w : eff_h;
        if (longest > limit)
        begin
            out_width  = scale_side(eff_w, limit, longest);
            out_height = scale_side(eff_h, limit, longest);
        end
        else
        begin
            out_width  = eff_w[12:0];
            out_height = eff_h[12:0];
        end
        src_col   = '0;
        src_row   = '0;
        out_col   = '0;
        out_row   = '0;
        col_numer = '0;
        row_numer = '0;
    endtask

    task automatic load_register(input logic [CFG_INDEX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_SOURCE_WIDTH:  reg_width  = value;
            CFG_SOURCE_HEIGHT: reg_height = value;
            CFG_MAX_DIMENSION: reg_max    = value[CFG_MAX_W-1:0];
            default:           return;
        endcase
        restart_geometry();
    endtask

    task automatic predict_pixel(input logic [PIXEL_W-1:0] data);
        logic   row_hit;
        logic   keep_it;
        logic   last_col;
        pixel_t want;
        row_hit = (row_numer / out_height) == src_row;
        keep_it = row_hit && ((col_numer / out_width) == src_col);
        if (keep_it)
        begin
            last_col        = (out_col + 13'd1) == out_width;
            want.blue       = data[23:16];
            want.green      = data[15:8];
            want.red        = data[7:0];
            want.alpha      = data[31:24];
            want.row_end    = last_col;
            want.frame_end  = last_col && ((out_row + 13'd1) == out_height);
            kept_pixels.push_back(want);
            out_col++;
            col_numer += eff_w;
        end
        if (src_col + 14'd1 >= eff_w)
        begin
            src_col   = '0;
            out_col   = '0;
            col_numer = '0;
            if (row_hit)
            begin
                out_row++;
                row_numer += eff_h;
            end
            if (src_row + 14'd1 >= eff_h)
            begin
                src_row   = '0;
                out_row   = '0;
                row_numer = '0;
            end
            else
            begin
                src_row++;
            end
        end
        else
        begin
            src_col++;
        end
    endtask

    task automatic note_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        failures++;
        if (failures <= 10)
        begin
            $display("%s mismatch: expected %h, actual %h", field, want, got);
        end
    endtask

    task automatic check_result(input pixel_t got);
        pixel_t want;
        if (kept_pixels.size() == 0)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("unexpected item: actual %h", got);
            end
            return;
        end
        want = kept_pixels.pop_front();
        if (got.blue != want.blue)           note_mismatch("blue", want.blue, got.blue);
        if (got.green != want.green)         note_mismatch("green", want.green, got.green);
        if (got.red != want.red)             note_mismatch("red", want.red, got.red);
        if (got.alpha != want.alpha)         note_mismatch("alpha", want.alpha, got.alpha);
        if (got.row_end != want.row_end)
            note_mismatch("row_end", 8'(want.row_end), 8'(got.row_end));
        if (got.frame_end != want.frame_end)
            note_mismatch("frame_end", 8'(want.frame_end), 8'(got.frame_end));
    endtask

    // scoreboard, predictor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                check_result({m_tuser, m_tlast, m_tdata});
            end
            if (cfg_valid && cfg_ready)
            begin
                load_register(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready)
            begin
                predict_pixel(s_tdata);
            end
            if ((m_tvalid && m_tready) || (cfg_valid && cfg_ready) || (s_tvalid && s_tready))
            begin
                quiet_count = 0;
            end
            else
            begin
                quiet_count++;
                if (quiet_count >= WATCHDOG_LIMIT)
                begin
                    $display("[FAIL] regression broken");
                    $finish;
                end
            end
        end
    end

    // output stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                sink_hold = draw_gap();
                if (sink_hold != 0)
                begin
                    m_tready <= 1'b0;
                end
            end
            else if (!m_tready)
            begin
                sink_hold--;
                if (sink_hold <= 0)
                begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] pixel);
        int gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel($urandom());
    endtask

    // hold input until every kept item has left, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (kept_pixels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_reset_geometry();
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'hA5A5_5A5A);
        send_pixel(32'h5A5A_A5A5);
        send_random(8);
    endtask

    task automatic check_pass_through();
        write_register(CFG_SOURCE_WIDTH, 14'd1);
        write_register(CFG_SOURCE_HEIGHT, 14'd1);
        send_random(3);
        write_register(CFG_SOURCE_WIDTH, 14'd3);
        write_register(CFG_SOURCE_HEIGHT, 14'd2);
        send_random(6);
    endtask

    task automatic check_side_saturation();
        write_register(CFG_SOURCE_WIDTH, 14'd0);
        write_register(CFG_SOURCE_HEIGHT, 14'h3FFF);
        write_register(CFG_MAX_DIMENSION, 14'd0);
        send_random(34);
        write_register(CFG_MAX_DIMENSION, 14'h3FFF);
        send_random(10);
        write_register(CFG_SOURCE_WIDTH, 14'h3FFF);
        write_register(CFG_SOURCE_HEIGHT, 14'd1);
        send_random(10);
        write_register(CFG_SOURCE_WIDTH, 14'd1024);
        write_register(CFG_SOURCE_HEIGHT, 14'd1024);
        write_register(CFG_MAX_DIMENSION, 14'd1024);
        send_random(4);
        write_register(CFG_MAX_DIMENSION, 14'd255);
        send_random(8);
    endtask

    task automatic check_spare_index();
        write_register(CFG_SOURCE_WIDTH, 14'd5);
        write_register(CFG_SOURCE_HEIGHT, 14'd2);
        write_register(CFG_MAX_DIMENSION, 14'd256);
        send_random(3);
        write_register(CFG_SPARE_INDEX, 14'h3FFF);
        send_random(7);
    endtask

    task automatic run_random_frames();
        int         goal;
        int         w;
        int         h;
        int         m;
        int         first;
        int         total;
        int         pause_at;
        int         phase;
        cfg_index_t idx;
        goal  = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < goal)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    w = $urandom_range(1, 16);
                    h = $urandom_range(1, 16);
                    m = $urandom_range(256, 1024);
                end
                1:
                begin
                    m = $urandom_range(256, 272);
                    w = $urandom_range(m + 1, m + 60);
                    h = $urandom_range(1, 2);
                end
                2:
                begin
                    m = $urandom_range(256, 272);
                    h = $urandom_range(m + 1, m + 40);
                    w = $urandom_range(1, 2);
                end
                default:
                begin
                    w = $urandom_range(1, 24);
                    h = $urandom_range(1, 24);
                    m = $urandom_range(0, 16383);
                end
            endcase
            first = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
            begin
                idx = cfg_index_t'((first + i) % 3);
                case (idx)
                    CFG_SOURCE_WIDTH:  write_register(idx, CFG_DATA_W'(w));
                    CFG_SOURCE_HEIGHT: write_register(idx, CFG_DATA_W'(h));
                    default:           write_register(idx, CFG_DATA_W'(m));
                endcase
            end
            no_idle = ($urandom_range(0, 3) == 0);
            total = $urandom_range(1, 2) * w * h;
            if (w * h > 1 && $urandom_range(0, 1) == 1)
            begin
                total += $urandom_range(1, w * h - 1);
            end
            pause_at = (phase == 0 || $urandom_range(0, 7) == 0) ?
                       $urandom_range(0, total - 1) : -1;
            for (int n = 0; n < total && items_sent < goal; n++)
            begin
                if (n == pause_at)
                begin
                    drain();
                end
                send_pixel($urandom());
            end
            no_idle = 1'b0;
            phase++;
        end
    endtask

    initial
    begin
        reg_width  = SOURCE_WIDTH_RESET;
        reg_height = SOURCE_HEIGHT_RESET;
        reg_max    = MAX_DIMENSION_RESET;
        restart_geometry();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        check_reset_geometry();
        check_pass_through();
        check_side_saturation();
        check_spare_index();
        run_random_frames();

        drain();
        repeat (20) @(posedge clk);
        if (failures == 0 && kept_pixels.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
